FILE: rtl/lzfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzfs_pkg
// Types and constants shared by the LZ flag-stream decompressor.
// ----------------------------------------------------------------------------
package lzfs_pkg;

  typedef enum logic [2:0] {
    PH_HDR_HI,
    PH_HDR_LO,
    PH_ITEM,
    PH_FAR_LO,
    PH_RUN,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PUT,
    S_COPY_RD,
    S_COPY_OUT,
    S_STATUS
  } ctl_state_t;

  localparam logic       KIND_DATA   = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;

  localparam logic [1:0] OST_EXACT    = 2'd0;
  localparam logic [1:0] OST_SHORT    = 2'd1;
  localparam logic [1:0] OST_OVER     = 2'd2;
  localparam logic [1:0] OST_BAD_DIST = 2'd3;

  localparam logic [1:0] IST_END   = 2'd0;
  localparam logic [1:0] IST_MORE  = 2'd1;
  localparam logic [1:0] IST_TRUNC = 2'd2;

  localparam logic [7:0] FLAG_END  = 8'h1F;
  localparam logic [7:0] FLAG_RUN  = 8'hC0;
  localparam logic [7:0] FLAG_NEAR = 8'h80;

  localparam logic [6:0] RUN_BASE      = 7'd8;
  localparam logic [5:0] NEAR_LEN_BIAS = 6'd6;
  localparam logic [5:0] FAR_LEN_BASE  = 6'd3;
  localparam logic [3:0] DESC_BITS     = 4'd8;

endpackage

FILE: rtl/lzfs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzfs_in_if / lzfs_out_if
// Valid/ready channels for compressed input bytes and decoded results.
// ----------------------------------------------------------------------------
interface lzfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzfs_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic        run_last;
  logic [1:0]  out_status;
  logic [1:0]  in_status;
  logic [15:0] header_size;

  modport source (output valid, output kind, output data_byte, output run_last,
                  output out_status, output in_status, output header_size,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input run_last,
                  input out_status, input in_status, input header_size,
                  output ready);
endinterface

FILE: rtl/lz_flag_stream_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_flag_stream_decompressor
// LZSS-style decoder with descriptor bits, literal runs and back-references.
// ----------------------------------------------------------------------------
// One compressed byte is taken at a time; the next is taken once its results
// are all loaded into the output register. Each byte is decoded first; a
// literal byte then goes to the output register and the history. Each byte of
// a back-reference is a read of the history RAM (registered read data)
// followed by its write-back and output. An end-of-stream status follows last.
// A full output register stalls decoding until it is taken. The history needs
// no clearing: reads are confined to bytes already written.
// ----------------------------------------------------------------------------
module lz_flag_stream_decompressor #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  lzfs_in_if.sink     in_chan,
  lzfs_out_if.source  out_chan
);
  import lzfs_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  ctl_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;

  logic [7:0]    byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic [7:0]    desc_bits_r, desc_bits_nxt;
  logic [3:0]    desc_left_r, desc_left_nxt;
  logic [15:0]   exp_size_r, exp_size_nxt;
  logic [16:0]   written_count_r, written_count_nxt;
  logic [6:0]    run_left_r, run_left_nxt;
  logic [7:0]    held_flag_r, held_flag_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [5:0]    copy_left_r, copy_left_nxt;
  logic          err_vld_r, err_vld_nxt;
  logic [1:0]    err_code_r, err_code_nxt;
  logic          ended_r, ended_nxt;

  logic          out_valid_r;
  logic          out_kind_r, out_run_last_r;
  logic [7:0]    out_data_r;
  logic [1:0]    out_ost_r, out_ist_r;
  logic [15:0]   out_hdr_r;

  logic          emit;
  logic          emit_kind, emit_run_last;
  logic [7:0]    emit_data;
  logic [1:0]    emit_ost, emit_ist;

  logic          slot_free;
  logic          over_size;
  logic          desc_bit;
  logic [9:0]    copy_dist;
  logic [5:0]    copy_len;
  logic          dist_bad;
  logic [AW:0]   src_diff;
  logic [AW-1:0] src_start;
  logic [AW-1:0] ptr_inc;
  logic [AW-1:0] src_inc;

  logic          hist_wr_en;
  logic [7:0]    hist_wr_data;
  logic          hist_rd_en;
  logic [7:0]    hist_rd_data;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign over_size = written_count_r >= {1'b0, exp_size_r};
  assign desc_bit  = desc_bits_r[0];

  assign copy_dist = (phase_r == PH_FAR_LO) ? {held_flag_r[6:5], byte_r}
                                            : {6'd0, byte_r[3:0]};
  assign copy_len  = (phase_r == PH_FAR_LO) ? ({1'b0, held_flag_r[4:0]} + FAR_LEN_BASE)
                                            : ({2'd0, byte_r[7:4]} - NEAR_LEN_BIAS);
  assign dist_bad  = (copy_dist == 10'd0) || (17'(copy_dist) > written_count_r);

  assign src_diff  = {1'b0, ptr_r} - (AW+1)'(copy_dist);
  assign src_start = src_diff[AW] ? AW'(src_diff + (AW+1)'(HISTORY_DEPTH))
                                  : src_diff[AW-1:0];
  assign ptr_inc   = (ptr_r == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  assign src_inc   = (src_r == AW'(HISTORY_DEPTH - 1)) ? '0 : src_r + 1'b1;

  assign in_chan.ready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = last_r ? S_STATUS : S_IDLE;
        unique case (phase_r)
          PH_ITEM: begin
            if (desc_left_r != 4'd0) begin
              if (!desc_bit) begin
                state_nxt = S_PUT;
              end else if (byte_r == FLAG_END) begin
                state_nxt = S_STATUS;
              end else if (byte_r >= FLAG_NEAR && byte_r < FLAG_RUN) begin
                state_nxt = dist_bad ? S_STATUS : S_COPY_RD;
              end
            end
          end
          PH_FAR_LO: state_nxt = dist_bad ? S_STATUS : S_COPY_RD;
          PH_RUN:    state_nxt = S_PUT;
          PH_SKIP:   state_nxt = S_IDLE;
          PH_HDR_HI, PH_HDR_LO: ;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_PUT: begin
        if (over_size)      state_nxt = S_STATUS;
        else if (slot_free) state_nxt = last_r ? S_STATUS : S_IDLE;
      end
      S_COPY_RD: begin
        state_nxt = over_size ? S_STATUS : S_COPY_OUT;
      end
      S_COPY_OUT: begin
        if (slot_free) begin
          if (copy_left_r == 6'd1) state_nxt = last_r ? S_STATUS : S_IDLE;
          else                     state_nxt = S_COPY_RD;
        end
      end
      S_STATUS: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_nxt         = phase_r;
    byte_nxt          = byte_r;
    last_nxt          = last_r;
    desc_bits_nxt     = desc_bits_r;
    desc_left_nxt     = desc_left_r;
    exp_size_nxt      = exp_size_r;
    written_count_nxt = written_count_r;
    run_left_nxt      = run_left_r;
    held_flag_nxt     = held_flag_r;
    ptr_nxt           = ptr_r;
    src_nxt           = src_r;
    copy_left_nxt     = copy_left_r;
    err_vld_nxt       = err_vld_r;
    err_code_nxt      = err_code_r;
    ended_nxt         = ended_r;
    emit              = 1'b0;
    emit_kind         = KIND_DATA;
    emit_data         = 8'd0;
    emit_run_last     = 1'b0;
    emit_ost          = OST_EXACT;
    emit_ist          = IST_END;
    hist_wr_en        = 1'b0;
    hist_wr_data      = byte_r;
    hist_rd_en        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          byte_nxt    = in_chan.in_byte;
          last_nxt    = in_chan.in_last;
          err_vld_nxt = 1'b0;
          ended_nxt   = 1'b0;
        end
      end
      S_DECODE: begin
        unique case (phase_r)
          PH_HDR_HI: begin
            exp_size_nxt = {byte_r, 8'd0};
            phase_nxt    = PH_HDR_LO;
          end
          PH_HDR_LO: begin
            exp_size_nxt = {exp_size_r[15:8], byte_r};
            phase_nxt    = PH_ITEM;
          end
          PH_ITEM: begin
            if (desc_left_r == 4'd0) begin
              desc_bits_nxt = byte_r;
              desc_left_nxt = DESC_BITS;
            end else begin
              desc_bits_nxt = {1'b0, desc_bits_r[7:1]};
              desc_left_nxt = desc_left_r - 1'b1;
              if (desc_bit) begin
                if (byte_r == FLAG_END) begin
                  ended_nxt = 1'b1;
                end else if (byte_r >= FLAG_RUN) begin
                  run_left_nxt = {1'b0, byte_r[5:0]} + RUN_BASE;
                  phase_nxt    = PH_RUN;
                end else if (byte_r >= FLAG_NEAR) begin
                  if (dist_bad) begin
                    err_vld_nxt  = 1'b1;
                    err_code_nxt = OST_BAD_DIST;
                  end
                  src_nxt       = src_start;
                  copy_left_nxt = copy_len;
                end else begin
                  held_flag_nxt = byte_r;
                  phase_nxt     = PH_FAR_LO;
                end
              end
            end
          end
          PH_FAR_LO: begin
            phase_nxt = PH_ITEM;
            if (dist_bad) begin
              err_vld_nxt  = 1'b1;
              err_code_nxt = OST_BAD_DIST;
            end
            src_nxt       = src_start;
            copy_left_nxt = copy_len;
          end
          PH_RUN: ;
          PH_SKIP: begin
            if (last_r) begin
              phase_nxt         = PH_HDR_HI;
              desc_bits_nxt     = 8'd0;
              desc_left_nxt     = 4'd0;
              exp_size_nxt      = 16'd0;
              written_count_nxt = 17'd0;
              run_left_nxt      = 7'd0;
              held_flag_nxt     = 8'd0;
              ptr_nxt           = '0;
            end
          end
          default: begin
            phase_nxt         = PH_HDR_HI;
            desc_bits_nxt     = 8'd0;
            desc_left_nxt     = 4'd0;
            exp_size_nxt      = 16'd0;
            written_count_nxt = 17'd0;
            run_left_nxt      = 7'd0;
            held_flag_nxt     = 8'd0;
            ptr_nxt           = '0;
          end
        endcase
      end
      S_PUT: begin
        if (over_size) begin
          err_vld_nxt  = 1'b1;
          err_code_nxt = OST_OVER;
        end else if (slot_free) begin
          emit              = 1'b1;
          emit_data         = byte_r;
          emit_run_last     = !last_r;
          hist_wr_en        = 1'b1;
          hist_wr_data      = byte_r;
          ptr_nxt           = ptr_inc;
          written_count_nxt = written_count_r + 1'b1;
          if (phase_r == PH_RUN) begin
            run_left_nxt = run_left_r - 1'b1;
            if (run_left_r == 7'd1) phase_nxt = PH_ITEM;
          end
        end
      end
      S_COPY_RD: begin
        if (over_size) begin
          err_vld_nxt  = 1'b1;
          err_code_nxt = OST_OVER;
        end else begin
          hist_rd_en = 1'b1;
        end
      end
      S_COPY_OUT: begin
        if (slot_free) begin
          emit              = 1'b1;
          emit_data         = hist_rd_data;
          emit_run_last     = (copy_left_r == 6'd1) && !last_r;
          hist_wr_en        = 1'b1;
          hist_wr_data      = hist_rd_data;
          ptr_nxt           = ptr_inc;
          src_nxt           = src_inc;
          written_count_nxt = written_count_r + 1'b1;
          copy_left_nxt     = copy_left_r - 1'b1;
        end
      end
      S_STATUS: begin
        if (slot_free) begin
          emit          = 1'b1;
          emit_kind     = KIND_STATUS;
          emit_run_last = 1'b1;
          if (err_vld_r) begin
            emit_ost = err_code_r;
            emit_ist = last_r ? IST_TRUNC : IST_MORE;
          end else begin
            emit_ost = (written_count_r < {1'b0, exp_size_r}) ? OST_SHORT : OST_EXACT;
            emit_ist = ended_r ? (last_r ? IST_END : IST_MORE) : IST_TRUNC;
          end
          if (last_r) begin
            phase_nxt         = PH_HDR_HI;
            desc_bits_nxt     = 8'd0;
            desc_left_nxt     = 4'd0;
            exp_size_nxt      = 16'd0;
            written_count_nxt = 17'd0;
            run_left_nxt      = 7'd0;
            held_flag_nxt     = 8'd0;
            ptr_nxt           = '0;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      phase_r         <= PH_HDR_HI;
      desc_bits_r     <= 8'd0;
      desc_left_r     <= 4'd0;
      exp_size_r      <= 16'd0;
      written_count_r <= 17'd0;
      run_left_r      <= 7'd0;
      held_flag_r     <= 8'd0;
      ptr_r           <= '0;
      copy_left_r     <= 6'd0;
      err_vld_r       <= 1'b0;
      err_code_r      <= OST_EXACT;
      ended_r         <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      phase_r         <= phase_nxt;
      desc_bits_r     <= desc_bits_nxt;
      desc_left_r     <= desc_left_nxt;
      exp_size_r      <= exp_size_nxt;
      written_count_r <= written_count_nxt;
      run_left_r      <= run_left_nxt;
      held_flag_r     <= held_flag_nxt;
      ptr_r           <= ptr_nxt;
      copy_left_r     <= copy_left_nxt;
      err_vld_r       <= err_vld_nxt;
      err_code_r      <= err_code_nxt;
      ended_r         <= ended_nxt;
      if (emit)                out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    src_r  <= src_nxt;
    if (emit) begin
      out_kind_r     <= emit_kind;
      out_data_r     <= emit_data;
      out_run_last_r <= emit_run_last;
      out_ost_r      <= emit_ost;
      out_ist_r      <= emit_ist;
      out_hdr_r      <= exp_size_r;
    end
  end

  lzfs_history #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_history (
    .clk       (clk),
    .wr_en     (hist_wr_en),
    .wr_addr   (ptr_r),
    .wr_data   (hist_wr_data),
    .rd_en     (hist_rd_en),
    .rd_addr   (src_r),
    .rd_data_r (hist_rd_data)
  );

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = out_kind_r;
  assign out_chan.data_byte   = out_data_r;
  assign out_chan.run_last    = out_run_last_r;
  assign out_chan.out_status  = out_ost_r;
  assign out_chan.in_status   = out_ist_r;
  assign out_chan.header_size = out_hdr_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    written_count_r <= {1'b0, exp_size_r})
    else $error("written count above header size");

  a_rd_not_wr_slot: assert property (@(posedge clk) disable iff (!rst_n)
    hist_rd_en |-> (src_r != ptr_r))
    else $error("copy source points at write slot");

  a_wr_emits_data: assert property (@(posedge clk) disable iff (!rst_n)
    hist_wr_en |=> (out_valid_r && out_kind_r == KIND_DATA))
    else $error("history write without data result");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STATUS && slot_free && last_r) |=>
      (phase_r == PH_HDR_HI && written_count_r == 17'd0 && state_r == S_IDLE))
    else $error("stream did not restart after final status");

  a_no_emit_in_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECODE && phase_r == PH_SKIP) |=> !$rose(out_valid_r))
    else $error("result produced while skipping");

endmodule

FILE: rtl/lzfs_history.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzfs_history
// History RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzfs_history #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

FILE: sim/tb_lz_flag_stream_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz_flag_stream_decompressor
// Streams compressed byte requests through the decompressor and checks every
// decoded byte and end-of-stream status against a cycle-free decode of the
// same bytes. Short directed streams come first. Random streams follow, most
// of them well-formed, with some truncated, oversized, corrupted or noise.
// ----------------------------------------------------------------------------
module tb_lz_flag_stream_decompressor;
  import lzfs_pkg::*;

  localparam int HIST_DEPTH   = 1024;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int PRINT_LIMIT  = 200;
  localparam int PHASE_BYTES  = 110;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } lz_req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        run_last;
    logic [1:0]  out_status;
    logic [1:0]  in_status;
    logic [15:0] header_size;
  } lz_result_t;

  logic clk;
  logic rst_n;

  lzfs_in_if  in_if ();
  lzfs_out_if out_if ();

  lz_flag_stream_decompressor #(.HISTORY_DEPTH(HIST_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  lz_req_t    compressed_q[$];
  lz_result_t decoded_q[$];
  lz_req_t    in_flight;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int cycle_count;

  // decoder state
  phase_t      dec_phase;
  logic [7:0]  desc_bits;
  logic [3:0]  desc_left;
  logic [15:0] hdr_size;
  logic [16:0] written;
  logic [6:0]  run_left;
  logic [7:0]  far_flag;
  logic [7:0]  hist [0:HIST_DEPTH-1];
  logic [9:0]  hist_ptr;

  always #2 clk = ~clk;

  task automatic restart_stream();
    dec_phase = PH_HDR_HI;
    desc_bits = '0;
    desc_left = '0;
    hdr_size  = '0;
    written   = '0;
    run_left  = '0;
    far_flag  = '0;
    hist_ptr  = '0;
  endtask

  task automatic emit_byte(input logic [7:0] v, output bit ok, inout int n);
    lz_result_t r;
    if (written >= {1'b0, hdr_size}) begin
      ok = 1'b0;
    end else begin
      hist[hist_ptr] = v;
      hist_ptr = hist_ptr + 10'd1;
      written = written + 17'd1;
      r = '{kind: KIND_DATA, data_byte: v, run_last: 1'b0, out_status: OST_EXACT,
            in_status: IST_END, header_size: hdr_size};
      decoded_q.push_back(r);
      n++;
      ok = 1'b1;
    end
  endtask

  task automatic copy_history(input int back_dist, input int len, inout int n,
                              inout bit has_err, inout logic [1:0] err_ost);
    int i;
    bit ok;
    logic [9:0] idx;
    if (back_dist == 0 || back_dist > int'(written) || back_dist > HIST_DEPTH) begin
      has_err = 1'b1;
      err_ost = OST_BAD_DIST;
      return;
    end
    for (i = 0; i < len; i++) begin
      idx = hist_ptr - 10'(back_dist);
      emit_byte(hist[idx], ok, n);
      if (!ok) begin
        has_err = 1'b1;
        err_ost = OST_OVER;
        return;
      end
    end
  endtask

  task automatic decode_request(input lz_req_t rq);
    int n;
    bit has_err;
    bit ended;
    bit ok;
    logic desc_bit;
    logic [1:0] err_ost;
    logic [1:0] ost;
    logic [1:0] ist;
    lz_result_t r;
    n = 0;
    has_err = 1'b0;
    ended = 1'b0;
    err_ost = OST_EXACT;
    case (dec_phase)
      PH_HDR_HI: begin
        hdr_size = {rq.data, 8'h00};
        dec_phase = PH_HDR_LO;
      end
      PH_HDR_LO: begin
        hdr_size[7:0] = rq.data;
        dec_phase = PH_ITEM;
      end
      PH_ITEM: begin
        if (desc_left == 4'd0) begin
          desc_bits = rq.data;
          desc_left = DESC_BITS;
        end else begin
          desc_bit = desc_bits[0];
          desc_bits = desc_bits >> 1;
          desc_left = desc_left - 4'd1;
          if (!desc_bit) begin
            emit_byte(rq.data, ok, n);
            if (!ok) begin
              has_err = 1'b1;
              err_ost = OST_OVER;
            end
          end else if (rq.data == FLAG_END) begin
            ended = 1'b1;
          end else if (rq.data >= FLAG_RUN) begin
            run_left = 7'(rq.data - FLAG_RUN) + RUN_BASE;
            dec_phase = PH_RUN;
          end else if (rq.data >= FLAG_NEAR) begin
            copy_history(int'(rq.data[3:0]), int'(rq.data[7:4]) - int'(NEAR_LEN_BIAS),
                         n, has_err, err_ost);
          end else begin
            far_flag = rq.data;
            dec_phase = PH_FAR_LO;
          end
        end
      end
      PH_FAR_LO: begin
        dec_phase = PH_ITEM;
        copy_history(int'({far_flag[6:5], rq.data}),
                     int'(far_flag[4:0]) + int'(FAR_LEN_BASE), n, has_err, err_ost);
      end
      PH_RUN: begin
        emit_byte(rq.data, ok, n);
        if (!ok) begin
          has_err = 1'b1;
          err_ost = OST_OVER;
        end else begin
          run_left = run_left - 7'd1;
          if (run_left == 7'd0) dec_phase = PH_ITEM;
        end
      end
      PH_SKIP: begin
        if (rq.is_last) restart_stream();
        return;
      end
      default: begin
        restart_stream();
        return;
      end
    endcase

    if (has_err || ended || rq.is_last) begin
      if (has_err) begin
        ost = err_ost;
        ist = rq.is_last ? IST_TRUNC : IST_MORE;
      end else begin
        ost = (written < {1'b0, hdr_size}) ? OST_SHORT : OST_EXACT;
        ist = ended ? (rq.is_last ? IST_END : IST_MORE) : IST_TRUNC;
      end
      r = '{kind: KIND_STATUS, data_byte: 8'h00, run_last: 1'b0, out_status: ost,
            in_status: ist, header_size: hdr_size};
      decoded_q.push_back(r);
      n++;
      if (rq.is_last) restart_stream();
      else dec_phase = PH_SKIP;
    end

    if (n > 0) begin
      r = decoded_q.pop_back();
      r.run_last = 1'b1;
      decoded_q.push_back(r);
    end
  endtask

  // One random stream: header, descriptor groups, copies that stay mostly in
  // range, then an end marker, garbage after it, or a cut at a random byte.
  task automatic compose_stream(output int pushed);
    lz_req_t body[$];
    logic [7:0] group_bytes[$];
    logic [7:0] desc;
    lz_req_t rq;
    int produced, items_left, slot, sel, back_dist, len, hdr, cut, maxd, k;
    bit done;
    if ($urandom_range(99) < 5) begin
      k = $urandom_range(1, 10);
      repeat (k) compressed_q.push_back('{data: 8'($urandom()), is_last: 1'b0});
      rq = compressed_q.pop_back();
      rq.is_last = 1'b1;
      compressed_q.push_back(rq);
      pushed = k;
      return;
    end

    items_left = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    produced = 0;
    done = 1'b0;
    while (!done) begin
      desc = 8'($urandom());
      group_bytes.delete();
      for (slot = 0; slot < 8 && !done; slot++) begin
        if (items_left == 0) begin
          desc[slot] = 1'b1;
          group_bytes.push_back(FLAG_END);
          done = 1'b1;
        end else begin
          items_left--;
          sel = $urandom_range(99);
          if (produced == 0 && sel >= 40) sel = sel % 40;
          if (sel < 25) begin
            desc[slot] = 1'b0;
            group_bytes.push_back(8'($urandom()));
            produced++;
          end else if (sel < 40) begin
            desc[slot] = 1'b1;
            len = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
            group_bytes.push_back(8'(FLAG_RUN + len));
            repeat (len + 8) group_bytes.push_back(8'($urandom()));
            produced += len + 8;
          end else if (sel < 70) begin
            desc[slot] = 1'b1;
            maxd = (produced < 15) ? produced : 15;
            back_dist = $urandom_range(1, maxd);
            if ($urandom_range(29) == 0)
              back_dist = ($urandom_range(1) == 0 || produced >= 15) ? 0 : produced + 1;
            len = $urandom_range(0, 3);
            group_bytes.push_back({2'b10, 2'(len), 4'(back_dist)});
            produced += len + 2;
          end else begin
            desc[slot] = 1'b1;
            maxd = (produced < 1023) ? produced : 1023;
            back_dist = $urandom_range(1, maxd);
            if ($urandom_range(29) == 0) back_dist = (produced >= 1023) ? 0 : produced + 1;
            len = $urandom_range(0, 31);
            if (back_dist < 256 && len == 31) len = 30;
            group_bytes.push_back({1'b0, 2'(back_dist >> 8), 5'(len)});
            group_bytes.push_back(8'(back_dist));
            produced += len + 3;
          end
        end
      end
      body.push_back('{data: desc, is_last: 1'b0});
      foreach (group_bytes[k]) body.push_back('{data: group_bytes[k], is_last: 1'b0});
    end

    hdr = produced;
    sel = $urandom_range(99);
    if (sel < 15) hdr = produced + $urandom_range(1, 20);
    else if (sel < 30 && produced > 0)
      hdr = produced - $urandom_range(1, (produced < 20) ? produced : 20);
    else if (sel < 33) hdr = 65535;
    body.push_front('{data: 8'(hdr), is_last: 1'b0});
    body.push_front('{data: 8'(hdr >> 8), is_last: 1'b0});

    sel = $urandom_range(99);
    if (sel < 10) begin
      repeat ($urandom_range(1, 3)) body.push_back('{data: 8'($urandom()), is_last: 1'b0});
    end else if (sel < 25) begin
      cut = $urandom_range(0, body.size() - 1);
      while (body.size() > cut + 1) void'(body.pop_back());
    end
    rq = body.pop_back();
    rq.is_last = 1'b1;
    body.push_back(rq);

    foreach (body[k]) compressed_q.push_back(body[k]);
    pushed = body.size();
  endtask

  task automatic fill_random(input int target);
    int total;
    int pushed;
    total = 0;
    while (total < target) begin
      compose_stream(pushed);
      total += pushed;
    end
  endtask

  task automatic wait_sent();
    while (compressed_q.size() != 0 || in_if.valid) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
    if (want_v != got_v) begin
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  task automatic check_result();
    lz_result_t got;
    lz_result_t want;
    got = '{kind: out_if.kind, data_byte: out_if.data_byte, run_last: out_if.run_last,
            out_status: out_if.out_status, in_status: out_if.in_status,
            header_size: out_if.header_size};
    if (decoded_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
    end else begin
      want = decoded_q.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("run_last", want.run_last, got.run_last);
      compare_field("out_status", want.out_status, got.out_status);
      compare_field("in_status", want.in_status, got.in_status);
      compare_field("header_size", want.header_size, got.header_size);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_request(in_flight);
      end
      if (!in_if.valid || in_if.ready) begin
        if (compressed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = compressed_q.pop_front();
          in_if.valid   <= 1'b1;
          in_if.in_byte <= in_flight.data;
          in_if.in_last <= in_flight.is_last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        check_result();
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // {in_last, byte}
  logic [8:0] directed_bytes[$] = '{
    // literals 00/FF, near copy, far copy, exact end marker
    9'h000, 9'h007, 9'h01C, 9'h000, 9'h0FF, 9'h081, 9'h000, 9'h002, 9'h11F,
    // literal run overruns header on the last byte
    9'h000, 9'h002, 9'h001, 9'h0C0, 9'h011, 9'h022, 9'h133,
    // distance beyond written bytes on the last byte
    9'h000, 9'h005, 9'h002, 9'h0AA, 9'h182,
    // zero distance mid-stream, rest skipped
    9'h000, 9'h001, 9'h001, 9'h080, 9'h100
  };

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.in_last = 1'b0;
    out_if.ready = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    send_idle_pct = 26;
    recv_idle_pct = 61;
    foreach (hist[i]) hist[i] = 8'h00;
    restart_stream();

    foreach (directed_bytes[i])
      compressed_q.push_back('{data: directed_bytes[i][7:0], is_last: directed_bytes[i][8]});
    fill_random(PHASE_BYTES);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait_sent();

    send_idle_pct = 61;
    recv_idle_pct = 26;
    fill_random(PHASE_BYTES);
    wait_sent();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(PHASE_BYTES);
    wait_sent();

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
